>>> rtl/leb_pkg.sv
// ---------------------------------------------------------------------------
// leb_pkg: shared types and codes for the line edit buffer
// Command codes and the packed input and result words of both channels.
// ---------------------------------------------------------------------------
package leb_pkg;

    // command codes
    localparam logic [3:0] FUNC_INSERT    = 4'd0;
    localparam logic [3:0] FUNC_SPACES    = 4'd1;
    localparam logic [3:0] FUNC_BACKSPACE = 4'd2;
    localparam logic [3:0] FUNC_DELETE    = 4'd3;
    localparam logic [3:0] FUNC_LEFT      = 4'd4;
    localparam logic [3:0] FUNC_RIGHT     = 4'd5;
    localparam logic [3:0] FUNC_HOME      = 4'd6;
    localparam logic [3:0] FUNC_END       = 4'd7;
    localparam logic [3:0] FUNC_CLEAR     = 4'd8;
    localparam logic [3:0] FUNC_READ      = 4'd9;
    localparam logic [3:0] FUNC_TAB       = 4'd10;

    localparam logic [7:0] SPACE_CHAR     = 8'h20;
    localparam logic [4:0] STOP_WIDTH_RST = 5'd4;
    localparam int         COL_BITS       = 9;

    typedef struct packed {
        logic [3:0] func;
        logic [7:0] char_in;
        logic [8:0] space_count;
        logic [7:0] read_index;
        logic [8:0] column;
    } t_in_word;

    typedef struct packed {
        logic       ok;
        logic [8:0] cursor_pos;
        logic [8:0] line_length;
        logic [7:0] char_out;
        logic [4:0] tab_spaces;
    } t_out_word;

endpackage

>>> rtl/line_edit_buffer.sv
// ---------------------------------------------------------------------------
// line_edit_buffer: one text line with an editing cursor
// Command word in, one result word out per command. The text sits in a
// single memory with a registered read port; edits move bytes through it.
// ---------------------------------------------------------------------------
// Use:
//   Input channel  i_in_valid / o_in_stall / i_in_data carries one command
//   word. Output channel o_out_valid / i_out_stall / o_out_data returns one
//   result word for each command, in order. i_cfg_we / i_cfg_data writes the
//   tab stop width (write only while idle).
// Per command: cursor moves, clear, refused commands and zero spaces make
// no memory pass; read makes one memory read; tab distance runs a
// bit-serial remainder, one column bit a cycle. Insert, spaces, backspace
// and delete shift the bytes behind the cursor with one memory read and
// one memory write per cycle, so the tail length sets the time taken;
// insert and spaces then write the new bytes into the gap.
// The next command is taken as soon as the previous one has left for the
// output register, even while that register is stalled; a finished result
// behind a stalled one waits in the sequencer and keeps o_in_stall high.
// Reset: cursor and length go to 0, tab width to 4; the text memory is not
// cleared (bytes past the length are never returned).
// ---------------------------------------------------------------------------
module line_edit_buffer #(
    parameter int CAPACITY = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  leb_pkg::t_in_word   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output leb_pkg::t_out_word  o_out_data,
    input  logic                i_cfg_we,
    input  logic [4:0]          i_cfg_data
);
    import leb_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > COL_BITS) ? LW : COL_BITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SHIFT = 3'd1;
    localparam logic [2:0] ST_FILL  = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // text store
    logic [7:0]    r_mem [CAPACITY];
    logic [7:0]    r_rdata;
    logic          mem_re;
    logic [AW-1:0] mem_ra;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;

    // control and line state
    logic [2:0]    r_state;
    logic [LW-1:0] r_cursor;
    logic [LW-1:0] r_length;
    logic [4:0]    r_stop_width;
    logic          r_out_valid;
    t_out_word     r_out;

    // shift sequencer
    logic          r_right;
    logic [AW-1:0] r_src;
    logic [LW-1:0] r_left;
    logic [LW-1:0] r_dist;
    logic          r_rd_v;
    logic [AW-1:0] r_wa;
    logic [AW-1:0] r_fill_addr;
    logic [7:0]    r_fill_byte;

    // remainder unit
    logic [4:0]    r_div_w;
    logic [4:0]    r_rem;
    logic [8:0]    r_col;
    logic [3:0]    r_div_cnt;

    // pending result fields
    logic          r_ok;
    logic [7:0]    r_char;
    logic [4:0]    r_tabs;

    logic          in_acc;
    logic          out_free;
    logic [CW-1:0] cnt_ext;
    logic [CW-1:0] room_ext;
    logic [CW-1:0] ridx_ext;
    logic [CW-1:0] len_ext;
    logic [CW-1:0] cur_ext;
    logic [5:0]    rem_try;
    logic [4:0]    rem_next;
    logic          n_ok;
    logic [2:0]    n_state;

    assign in_acc      = (r_state == ST_IDLE) && i_in_valid;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign cnt_ext  = CW'(i_in_data.space_count);
    assign ridx_ext = CW'(i_in_data.read_index);
    assign len_ext  = CW'(r_length);
    assign cur_ext  = CW'(r_cursor);
    assign room_ext = CW'(CAPACITY) - len_ext;

    // one restoring step of column mod width
    assign rem_try  = {r_rem, r_col[8]};
    assign rem_next = (rem_try >= {1'b0, r_div_w}) ? 5'(rem_try - {1'b0, r_div_w})
                                                   : rem_try[4:0];

    // accept decision and follow-up state for the command at the input
    always_comb begin
        n_ok    = 1'b0;
        n_state = ST_DONE;
        unique case (i_in_data.func)
            FUNC_INSERT: begin
                n_ok    = (r_length != LW'(CAPACITY));
                n_state = n_ok ? ST_SHIFT : ST_DONE;
            end
            FUNC_SPACES: begin
                n_ok    = (cnt_ext <= room_ext);
                n_state = (n_ok && (cnt_ext != '0)) ? ST_SHIFT : ST_DONE;
            end
            FUNC_BACKSPACE: begin
                n_ok    = (r_cursor != '0);
                n_state = n_ok ? ST_SHIFT : ST_DONE;
            end
            FUNC_DELETE: begin
                n_ok    = (r_cursor < r_length);
                n_state = n_ok ? ST_SHIFT : ST_DONE;
            end
            FUNC_LEFT: begin
                n_ok = (r_cursor != '0);
            end
            FUNC_RIGHT: begin
                n_ok = (r_cursor < r_length);
            end
            FUNC_HOME: begin
                n_ok = (r_cursor != '0);
            end
            FUNC_END: begin
                n_ok = (r_cursor != r_length);
            end
            FUNC_CLEAR: begin
                n_ok = 1'b1;
            end
            FUNC_READ: begin
                n_ok    = (ridx_ext < len_ext);
                n_state = n_ok ? ST_READ : ST_DONE;
            end
            FUNC_TAB: begin
                n_ok    = 1'b1;
                n_state = ST_DIV;
            end
            default: begin
            end
        endcase
    end

    // memory port selection
    always_comb begin
        mem_re = 1'b0;
        mem_ra = r_src;
        mem_we = 1'b0;
        mem_wa = r_wa;
        mem_wd = r_rdata;
        unique case (r_state)
            ST_IDLE: begin
                mem_re = in_acc && (i_in_data.func == FUNC_READ);
                mem_ra = ridx_ext[AW-1:0];
            end
            ST_SHIFT: begin
                mem_re = (r_left != '0);
                mem_we = r_rd_v;
            end
            ST_FILL: begin
                mem_we = (r_left != '0);
                mem_wa = r_fill_addr;
                mem_wd = r_fill_byte;
            end
            default: begin
            end
        endcase
    end

    // single read port, single write port; a shift never reads the entry
    // written in the same cycle, so no forwarding is needed
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    // command sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cursor     <= '0;
            r_length     <= '0;
            r_stop_width <= STOP_WIDTH_RST;
            r_out_valid  <= 1'b0;
            r_rd_v       <= 1'b0;
            r_left       <= '0;
            r_div_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_stop_width <= i_cfg_data;
            end
            // output word taken; a new one loaded in ST_DONE takes its place
            if (r_out_valid && !i_out_stall && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_ok    <= n_ok;
                        r_char  <= '0;
                        r_tabs  <= '0;
                        r_state <= n_state;
                        unique case (i_in_data.func)
                            FUNC_INSERT: begin
                                if (r_length != LW'(CAPACITY)) begin
                                    r_right     <= 1'b1;
                                    r_src       <= AW'(r_length - 1'b1);
                                    r_left      <= r_length - r_cursor;
                                    r_dist      <= LW'(1);
                                    r_fill_addr <= AW'(r_cursor);
                                    r_fill_byte <= i_in_data.char_in;
                                    r_cursor    <= r_cursor + 1'b1;
                                    r_length    <= r_length + 1'b1;
                                end
                            end
                            FUNC_SPACES: begin
                                if ((cnt_ext <= room_ext) && (cnt_ext != '0)) begin
                                    r_right     <= 1'b1;
                                    r_src       <= AW'(r_length - 1'b1);
                                    r_left      <= r_length - r_cursor;
                                    r_dist      <= cnt_ext[LW-1:0];
                                    r_fill_addr <= AW'(r_cursor);
                                    r_fill_byte <= SPACE_CHAR;
                                    r_cursor    <= r_cursor + cnt_ext[LW-1:0];
                                    r_length    <= r_length + cnt_ext[LW-1:0];
                                end
                            end
                            FUNC_BACKSPACE: begin
                                if (r_cursor != '0) begin
                                    r_right  <= 1'b0;
                                    r_src    <= AW'(r_cursor);
                                    r_left   <= r_length - r_cursor;
                                    r_cursor <= r_cursor - 1'b1;
                                    r_length <= r_length - 1'b1;
                                end
                            end
                            FUNC_DELETE: begin
                                if (r_cursor < r_length) begin
                                    r_right  <= 1'b0;
                                    r_src    <= AW'(r_cursor + 1'b1);
                                    r_left   <= r_length - r_cursor - 1'b1;
                                    r_length <= r_length - 1'b1;
                                end
                            end
                            FUNC_LEFT: begin
                                if (r_cursor != '0) begin
                                    r_cursor <= r_cursor - 1'b1;
                                end
                            end
                            FUNC_RIGHT: begin
                                if (r_cursor < r_length) begin
                                    r_cursor <= r_cursor + 1'b1;
                                end
                            end
                            FUNC_HOME: begin
                                if (r_cursor != '0) begin
                                    r_cursor <= '0;
                                end
                            end
                            FUNC_END: begin
                                if (r_cursor != r_length) begin
                                    r_cursor <= r_length;
                                end
                            end
                            FUNC_CLEAR: begin
                                r_cursor <= '0;
                                r_length <= '0;
                            end
                            FUNC_TAB: begin
                                r_div_w   <= (r_stop_width == '0) ? 5'd1 : r_stop_width;
                                r_rem     <= '0;
                                r_col     <= i_in_data.column;
                                r_div_cnt <= 4'(COL_BITS);
                            end
                            // read is issued on the memory port above
                            default: begin
                            end
                        endcase
                    end
                end

                // pipelined copy: read at r_src, write of that byte in the next cycle
                ST_SHIFT: begin
                    r_rd_v <= (r_left != '0);
                    if (r_left != '0) begin
                        r_left <= r_left - 1'b1;
                        r_wa   <= r_right ? AW'(r_src + AW'(r_dist)) : AW'(r_src - 1'b1);
                        r_src  <= r_right ? AW'(r_src - 1'b1) : AW'(r_src + 1'b1);
                    end else if (!r_rd_v) begin
                        if (r_right) begin
                            r_left  <= r_dist;
                            r_state <= ST_FILL;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end

                // write the new bytes into the gap
                ST_FILL: begin
                    if (r_left != '0) begin
                        r_left      <= r_left - 1'b1;
                        r_fill_addr <= AW'(r_fill_addr + 1'b1);
                    end else begin
                        r_state <= ST_DONE;
                    end
                end

                ST_READ: begin
                    r_char  <= r_rdata;
                    r_state <= ST_DONE;
                end

                ST_DIV: begin
                    if (r_div_cnt != '0) begin
                        r_rem     <= rem_next;
                        r_col     <= {r_col[7:0], 1'b0};
                        r_div_cnt <= r_div_cnt - 1'b1;
                    end else begin
                        r_tabs  <= (r_rem == '0) ? r_div_w : 5'(r_div_w - r_rem);
                        r_state <= ST_DONE;
                    end
                end

                // hand the result to the output register
                ST_DONE: begin
                    if (out_free) begin
                        r_out.ok          <= r_ok;
                        r_out.cursor_pos  <= cur_ext[8:0];
                        r_out.line_length <= len_ext[8:0];
                        r_out.char_out    <= r_char;
                        r_out.tab_spaces  <= r_tabs;
                        r_out_valid       <= 1'b1;
                        r_state           <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
